>>> hw/rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the segment intersection test
// Point, difference-vector and product-term numbering used by the stages,
// plus the flag and sign records that travel down the pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

  // Input beat: eight coordinate fields, each carried at full field width.
  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned NUM_FIELDS = 8;

  // Endpoints; field 2*p is x and field 2*p+1 is y of point p.
  localparam int unsigned PT_A1 = 0;
  localparam int unsigned PT_A2 = 1;
  localparam int unsigned PT_B1 = 2;
  localparam int unsigned PT_B2 = 3;

  // Difference vectors (minuend point minus subtrahend point).
  localparam int unsigned NUM_VEC   = 10;
  localparam int unsigned VEC_DA    = 0;
  localparam int unsigned VEC_DB    = 1;
  localparam int unsigned VEC_A1B1  = 2;
  localparam int unsigned VEC_A1B2  = 3;
  localparam int unsigned VEC_B1A1  = 4;
  localparam int unsigned VEC_B1A2  = 5;
  localparam int unsigned VEC_B2A1  = 6;
  localparam int unsigned VEC_B2A2  = 7;
  localparam int unsigned VEC_A2B1  = 8;
  localparam int unsigned VEC_A2B2  = 9;

  localparam int unsigned VEC_MIN [NUM_VEC] = '{
    PT_A2, PT_B2, PT_A1, PT_A1, PT_B1, PT_B1, PT_B2, PT_B2, PT_A2, PT_A2
  };
  localparam int unsigned VEC_SUB [NUM_VEC] = '{
    PT_A1, PT_B1, PT_B1, PT_B2, PT_A1, PT_A2, PT_A1, PT_A2, PT_B1, PT_B2
  };

  // Product terms: cross(p, q) = p.x*q.y - p.y*q.x, dot(p, q) = p.x*q.x + p.y*q.y.
  localparam int unsigned NUM_TERMS   = 9;
  localparam int unsigned T_C_DB_A1   = 0;  // cross(db, a1 - b1)
  localparam int unsigned T_C_DA_B1   = 1;  // cross(da, b1 - a1)
  localparam int unsigned T_C_DA_B2   = 2;  // cross(da, b2 - a1)
  localparam int unsigned T_C_DB_A2   = 3;  // cross(db, a2 - b1)
  localparam int unsigned T_C_DA_DB   = 4;  // cross(da, db)
  localparam int unsigned T_W_A1      = 5;  // a1 within b1..b2
  localparam int unsigned T_W_B1      = 6;  // b1 within a1..a2
  localparam int unsigned T_W_B2      = 7;  // b2 within a1..a2
  localparam int unsigned T_W_A2      = 8;  // a2 within b1..b2

  localparam int unsigned TERM_P [NUM_TERMS] = '{
    VEC_DB, VEC_DA, VEC_DA, VEC_DB, VEC_DA, VEC_A1B1, VEC_B1A1, VEC_B2A1, VEC_A2B1
  };
  localparam int unsigned TERM_Q [NUM_TERMS] = '{
    VEC_A1B1, VEC_B1A1, VEC_B2A1, VEC_A2B1, VEC_DB, VEC_A1B2, VEC_B1A2, VEC_B2A2,
    VEC_A2B2
  };
  localparam bit TERM_DOT [NUM_TERMS] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1
  };

  // Degenerate-segment flags, carried alongside the arithmetic.
  typedef struct packed {
    logic da_zero;
    logic db_zero;
  } pair_flags_t;

  // Exact sign of one product term.
  typedef struct packed {
    logic neg;
    logic zero;
  } term_sign_t;

endpackage

>>> hw/rtl/sit_if.sv
// ----------------------------------------------------------------------------
// sit_if: valid/ready channels of the segment intersection test
// seg_pair_if carries one pair of segments, touch_if carries the verdict.
// ----------------------------------------------------------------------------
interface seg_pair_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sit_pkg::FIELD_BITS-1:0] seg_a_start_x;
  logic signed [sit_pkg::FIELD_BITS-1:0] seg_a_start_y;
  logic signed [sit_pkg::FIELD_BITS-1:0] seg_a_end_x;
  logic signed [sit_pkg::FIELD_BITS-1:0] seg_a_end_y;
  logic signed [sit_pkg::FIELD_BITS-1:0] seg_b_start_x;
  logic signed [sit_pkg::FIELD_BITS-1:0] seg_b_start_y;
  logic signed [sit_pkg::FIELD_BITS-1:0] seg_b_end_x;
  logic signed [sit_pkg::FIELD_BITS-1:0] seg_b_end_y;

  modport source (
    output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    input  ready
  );
  modport sink (
    input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    output ready
  );
endinterface

interface touch_if;
  logic valid;
  logic ready;
  logic segments_touch;

  modport source (output valid, segments_touch, input ready);
  modport sink (input valid, segments_touch, output ready);
endinterface

>>> hw/rtl/sit_diff.sv
// ----------------------------------------------------------------------------
// sit_diff: difference stage
// Sign-extends the coordinates and registers the ten difference vectors.
// ----------------------------------------------------------------------------
module sit_diff #(
  parameter int COORD_BITS = 32
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   en,
  input  logic                                                   in_valid,
  input  logic [sit_pkg::NUM_FIELDS-1:0][sit_pkg::FIELD_BITS-1:0] coords,
  output logic                                                   valid,
  output logic [2*sit_pkg::NUM_VEC-1:0][COORD_BITS:0]            diffs,
  output sit_pkg::pair_flags_t                                   flags
);

  localparam int DW = COORD_BITS + 1;

  logic [2*sit_pkg::NUM_VEC-1:0][DW-1:0] diffs_next;
  sit_pkg::pair_flags_t                  flags_next;

  for (genvar v = 0; v < sit_pkg::NUM_VEC; v++) begin : g_vec
    for (genvar c = 0; c < 2; c++) begin : g_comp
      localparam int FM = 2 * sit_pkg::VEC_MIN[v] + c;
      localparam int FS = 2 * sit_pkg::VEC_SUB[v] + c;
      logic [DW-1:0] lhs;
      logic [DW-1:0] rhs;
      // take the low coordinate bits and sign-extend by one
      assign lhs = {coords[FM][COORD_BITS-1], coords[FM][COORD_BITS-1:0]};
      assign rhs = {coords[FS][COORD_BITS-1], coords[FS][COORD_BITS-1:0]};
      assign diffs_next[2*v+c] = lhs - rhs;
    end
  end

  always_comb begin
    flags_next.da_zero = (diffs_next[2*sit_pkg::VEC_DA] == '0) &&
                         (diffs_next[2*sit_pkg::VEC_DA+1] == '0);
    flags_next.db_zero = (diffs_next[2*sit_pkg::VEC_DB] == '0) &&
                         (diffs_next[2*sit_pkg::VEC_DB+1] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diffs <= diffs_next;
      flags <= flags_next;
    end
  end

endmodule

>>> hw/rtl/sit_mul.sv
// ----------------------------------------------------------------------------
// sit_mul: product stage
// Forms both partial products of every cross and dot term at full width.
// ----------------------------------------------------------------------------
module sit_mul #(
  parameter int COORD_BITS = 32
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              en,
  input  logic                                              in_valid,
  input  logic [2*sit_pkg::NUM_VEC-1:0][COORD_BITS:0]       diffs,
  input  sit_pkg::pair_flags_t                              in_flags,
  output logic                                              valid,
  output logic [2*sit_pkg::NUM_TERMS-1:0][2*COORD_BITS+1:0] prods,
  output sit_pkg::pair_flags_t                              flags
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic [2*sit_pkg::NUM_TERMS-1:0][PW-1:0] prods_next;

  for (genvar t = 0; t < sit_pkg::NUM_TERMS; t++) begin : g_term
    localparam int PI = 2 * sit_pkg::TERM_P[t];
    localparam int QI = 2 * sit_pkg::TERM_Q[t];
    // cross pairs p.x with q.y, dot pairs p.x with q.x
    localparam int Q0 = sit_pkg::TERM_DOT[t] ? QI : QI + 1;
    localparam int Q1 = sit_pkg::TERM_DOT[t] ? QI + 1 : QI;
    logic signed [DW-1:0] p0;
    logic signed [DW-1:0] p1;
    logic signed [DW-1:0] q0;
    logic signed [DW-1:0] q1;
    assign p0 = diffs[PI];
    assign p1 = diffs[PI+1];
    assign q0 = diffs[Q0];
    assign q1 = diffs[Q1];
    assign prods_next[2*t]   = p0 * q0;
    assign prods_next[2*t+1] = p1 * q1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prods <= prods_next;
      flags <= in_flags;
    end
  end

endmodule

>>> hw/rtl/sit_sign.sv
// ----------------------------------------------------------------------------
// sit_sign: sign stage
// Adds or subtracts each product pair and keeps only the exact sign.
// ----------------------------------------------------------------------------
module sit_sign #(
  parameter int COORD_BITS = 32
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              en,
  input  logic                                              in_valid,
  input  logic [2*sit_pkg::NUM_TERMS-1:0][2*COORD_BITS+1:0] prods,
  input  sit_pkg::pair_flags_t                              in_flags,
  output logic                                              valid,
  output sit_pkg::term_sign_t [sit_pkg::NUM_TERMS-1:0]      signs,
  output sit_pkg::pair_flags_t                              flags
);

  localparam int PW = 2 * COORD_BITS + 2;
  localparam int SW = PW + 1;

  sit_pkg::term_sign_t [sit_pkg::NUM_TERMS-1:0] signs_next;

  for (genvar t = 0; t < sit_pkg::NUM_TERMS; t++) begin : g_term
    logic [SW-1:0] m0;
    logic [SW-1:0] m1;
    logic [SW-1:0] total;
    assign m0 = {prods[2*t][PW-1], prods[2*t]};
    assign m1 = {prods[2*t+1][PW-1], prods[2*t+1]};
    if (sit_pkg::TERM_DOT[t]) begin : g_dot
      assign total = m0 + m1;
    end else begin : g_cross
      assign total = m0 - m1;
    end
    assign signs_next[t].neg  = total[SW-1];
    assign signs_next[t].zero = (total == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      signs <= signs_next;
      flags <= in_flags;
    end
  end

endmodule

>>> hw/rtl/sit_decide.sv
// ----------------------------------------------------------------------------
// sit_decide: verdict stage
// Combines the term signs into the touch verdict and holds the output beat.
// ----------------------------------------------------------------------------
module sit_decide (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  sit_pkg::term_sign_t [sit_pkg::NUM_TERMS-1:0] signs,
  input  sit_pkg::pair_flags_t                         flags,
  output logic                                         valid,
  output logic                                         touch
);

  logic touch_next;
  logic w_a1;
  logic w_a2;
  logic w_b1;
  logic w_b2;
  logic a_straddles;
  logic b_straddles;

  always_comb begin
    // a point lies within a span when its dot product is not positive
    w_a1 = signs[sit_pkg::T_W_A1].neg | signs[sit_pkg::T_W_A1].zero;
    w_a2 = signs[sit_pkg::T_W_A2].neg | signs[sit_pkg::T_W_A2].zero;
    w_b1 = signs[sit_pkg::T_W_B1].neg | signs[sit_pkg::T_W_B1].zero;
    w_b2 = signs[sit_pkg::T_W_B2].neg | signs[sit_pkg::T_W_B2].zero;
    // reject only when both ends sit strictly on one side
    a_straddles = signs[sit_pkg::T_C_DA_B1].zero || signs[sit_pkg::T_C_DA_B2].zero ||
                  (signs[sit_pkg::T_C_DA_B1].neg != signs[sit_pkg::T_C_DA_B2].neg);
    b_straddles = signs[sit_pkg::T_C_DB_A1].zero || signs[sit_pkg::T_C_DB_A2].zero ||
                  (signs[sit_pkg::T_C_DB_A1].neg != signs[sit_pkg::T_C_DB_A2].neg);
    priority if (flags.da_zero) begin
      touch_next = signs[sit_pkg::T_C_DB_A1].zero && w_a1;
    end else if (flags.db_zero) begin
      touch_next = signs[sit_pkg::T_C_DA_B1].zero && w_b1;
    end else if (signs[sit_pkg::T_C_DA_DB].zero) begin
      touch_next = signs[sit_pkg::T_C_DA_B1].zero && (w_a1 || w_a2 || w_b1 || w_b2);
    end else begin
      touch_next = a_straddles && b_straddles;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      touch <= touch_next;
    end
  end

endmodule

>>> hw/rtl/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// segment_intersection_test: closed line segment intersection test
// Decides whether two integer segments share a point, using exact signs of
// cross and dot products in a four-stage pipeline.
//
//   channel  dir  modport           payload
//   pairs    in   seg_pair_if.sink  seg_a/b start/end x/y, 32 bits signed each
//   result   out  touch_if.source   segments_touch, 1 bit
//
// One pair enters per cycle unless a stall on result backs up the pipeline;
// its verdict passes the difference, product, sign and verdict registers.
// Reset (synchronous, rst high) drops every beat in flight; the data
// registers are not reset.
// A stall on result holds the output beat; the stages behind it close up
// their bubbles and then hold, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module segment_intersection_test #(
  parameter int COORD_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  seg_pair_if.sink          pairs,
  touch_if.source           result
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  // Per-stage advance: a stage loads when it is empty or its occupant moves on.
  logic en_diff;
  logic en_mul;
  logic en_sign;
  logic en_out;

  logic [sit_pkg::NUM_FIELDS-1:0][sit_pkg::FIELD_BITS-1:0] coords;

  logic                                    diff_valid;
  logic [2*sit_pkg::NUM_VEC-1:0][DW-1:0]   diffs;
  sit_pkg::pair_flags_t                    diff_flags;

  logic                                    mul_valid;
  logic [2*sit_pkg::NUM_TERMS-1:0][PW-1:0] prods;
  sit_pkg::pair_flags_t                    mul_flags;

  logic                                         sign_valid;
  sit_pkg::term_sign_t [sit_pkg::NUM_TERMS-1:0] signs;
  sit_pkg::pair_flags_t                         sign_flags;

  // Gather the fields in point order: a start, a end, b start, b end.
  always_comb begin
    coords[2*sit_pkg::PT_A1]     = pairs.seg_a_start_x;
    coords[2*sit_pkg::PT_A1 + 1] = pairs.seg_a_start_y;
    coords[2*sit_pkg::PT_A2]     = pairs.seg_a_end_x;
    coords[2*sit_pkg::PT_A2 + 1] = pairs.seg_a_end_y;
    coords[2*sit_pkg::PT_B1]     = pairs.seg_b_start_x;
    coords[2*sit_pkg::PT_B1 + 1] = pairs.seg_b_start_y;
    coords[2*sit_pkg::PT_B2]     = pairs.seg_b_end_x;
    coords[2*sit_pkg::PT_B2 + 1] = pairs.seg_b_end_y;
  end

  // Advance chain, back from the output register.
  assign en_out      = !result.valid || result.ready;
  assign en_sign     = !sign_valid || en_out;
  assign en_mul      = !mul_valid || en_sign;
  assign en_diff     = !diff_valid || en_mul;
  assign pairs.ready = en_diff;

  // Stage 1: difference vectors and degenerate-segment flags.
  sit_diff #(
    .COORD_BITS (COORD_BITS)
  ) u_diff (
    .clk      (clk),
    .rst      (rst),
    .en       (en_diff),
    .in_valid (pairs.valid),
    .coords   (coords),
    .valid    (diff_valid),
    .diffs    (diffs),
    .flags    (diff_flags)
  );

  // Stage 2: eighteen full-width products.
  sit_mul #(
    .COORD_BITS (COORD_BITS)
  ) u_mul (
    .clk      (clk),
    .rst      (rst),
    .en       (en_mul),
    .in_valid (diff_valid),
    .diffs    (diffs),
    .in_flags (diff_flags),
    .valid    (mul_valid),
    .prods    (prods),
    .flags    (mul_flags)
  );

  // Stage 3: exact sign of each cross and dot term.
  sit_sign #(
    .COORD_BITS (COORD_BITS)
  ) u_sign (
    .clk      (clk),
    .rst      (rst),
    .en       (en_sign),
    .in_valid (mul_valid),
    .prods    (prods),
    .in_flags (mul_flags),
    .valid    (sign_valid),
    .signs    (signs),
    .flags    (sign_flags)
  );

  // Stage 4: verdict, held in the output register until taken.
  sit_decide u_decide (
    .clk      (clk),
    .rst      (rst),
    .en       (en_out),
    .in_valid (sign_valid),
    .signs    (signs),
    .flags    (sign_flags),
    .valid    (result.valid),
    .touch    (result.segments_touch)
  );

endmodule
